/* hdl/lzfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZF decompressor package
// Shared constants and types of the LZF stream decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;
	localparam int HistDepth = 8192;
	localparam int HistAw = $clog2(HistDepth);
	localparam int Lanes = 8;
	localparam int CountW = 24;
	localparam logic [CountW-1:0] LimitReset = 24'hFFFFFF;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_LIMIT = 2'd1,
		ST_BEFORE = 2'd2,
		ST_TRUNC = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_CTRL = 2'd0,
		PH_LIT = 2'd1,
		PH_EXT = 2'd2,
		PH_OFF = 2'd3
	} phase_t;
endpackage
`default_nettype wire

/* hdl/lzfd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZF decompressor RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzfd_ram #(
	parameter int Width = 8,
	parameter int Depth = 8192
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/lzf_stream_decompressor_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZF stream decompressor
// Decodes an LZF byte stream through an 8192-byte history RAM.
// ----------------------------------------------------------------------------
// Compressed bytes enter on the s_axis channel, one word per byte, with
// tlast marking the last byte of a block. Results leave on m_axis: up to
// eight decompressed bytes in tdata, and in tuser the byte count, the
// end-of-byte flag, the block-done flag and the status code.
// The cfg channel writes the output limit; the user must write it only while
// the block is idle, as the block itself does not enforce this. A control,
// extension or offset byte gives no word unless it ends a block or raises an
// error. A literal byte gives one word, registered at its acceptance. A back
// reference first fetches its first byte, then copies one byte per cycle
// through the history RAM while the output register is free (one read, one
// write a cycle, registered read, with same-address forwarding); a copy of n
// bytes gives ceil(n / 8) words.
// Reset clears the token state, the byte count and the limit (to all ones);
// the history needs no clearing. When the receiver stalls, the output
// register holds its word and the copy engine waits; input is taken only
// when no copy is running and the output register is free.
// ----------------------------------------------------------------------------
module lzf_stream_decompressor_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // in_byte
	input wire logic s_axis_tlast, // block_end
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [63:0] m_axis_tdata, // data_bytes
	output logic [7:0] m_axis_tuser, // byte_count[3:0], run_end, block_done, status[1:0]
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [23:0] cfg_data
);
	localparam int Aw = lzfd_pkg::HistAw;
	localparam int Cw = lzfd_pkg::CountW;

	logic [Cw-1:0] limit_q, prod_q;
	lzfd_pkg::phase_t phase_q;
	logic [5:0] lit_q;
	logic [8:0] clen_q;
	logic [4:0] offh_q;
	logic err_q;

	// copy engine
	logic copy_q, rd_pend_q, last_q;
	logic [8:0] left_q; // bytes still to be read
	logic [Aw-1:0] rptr_q;
	logic [3:0] n_q;
	logic [63:0] acc_q;
	logic [7:0] fwd_q;
	logic fwd_use_q;

	// output register
	logic ov_q;
	logic [63:0] od_q;
	logic [3:0] oc_q;
	logic ore_q, obd_q;
	logic [1:0] ost_q;

	logic [7:0] rdata, cbyte;
	logic we;
	logic [Aw-1:0] waddr;
	logic [Aw-1:0] raddr;
	logic [7:0] wdata;
	logic out_free, acc_in, advance;
	logic [Cw:0] need;
	logic [13:0] back_dist;

	assign out_free = !ov_q || m_axis_tready;
	assign s_axis_tready = !copy_q && out_free;
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = {ost_q, obd_q, ore_q, oc_q};

	// rptr_q addresses the byte in rdata; the read moves on as it is used.
	assign advance = copy_q && rd_pend_q && out_free;
	assign raddr = advance ? rptr_q + 1'b1 : rptr_q;

	assign cbyte = fwd_use_q ? fwd_q : rdata;
	assign back_dist = {1'b0, offh_q, s_axis_tdata} + 14'd1;

	always_comb begin
		need = {1'b0, prod_q} + (phase_q == lzfd_pkg::PH_CTRL ?
			{{(Cw-5){1'b0}}, 6'({1'b0, s_axis_tdata[4:0]} + 6'd1)} :
			{{(Cw-9){1'b0}}, 10'({1'b0, clen_q} + 10'd2)});
		we = 1'b0;
		waddr = prod_q[Aw-1:0];
		wdata = s_axis_tdata;
		if (advance) begin
			we = 1'b1;
			wdata = cbyte;
		end else if (acc_in && !err_q && phase_q == lzfd_pkg::PH_LIT) begin
			we = 1'b1;
		end
	end

	lzfd_ram #(.Width(8), .Depth(lzfd_pkg::HistDepth)) u_hist (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lzfd_pkg::LimitReset;
			prod_q <= '0;
			phase_q <= lzfd_pkg::PH_CTRL;
			lit_q <= '0;
			clen_q <= '0;
			offh_q <= '0;
			err_q <= 1'b0;
			copy_q <= 1'b0;
			rd_pend_q <= 1'b0;
			last_q <= 1'b0;
			left_q <= '0;
			rptr_q <= '0;
			n_q <= '0;
			acc_q <= '0;
			fwd_q <= '0;
			fwd_use_q <= 1'b0;
			ov_q <= 1'b0;
			od_q <= '0;
			oc_q <= '0;
			ore_q <= 1'b0;
			obd_q <= 1'b0;
			ost_q <= lzfd_pkg::ST_OK;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			if (copy_q) begin
				if (!rd_pend_q) begin
					// The first source byte is being read this cycle.
					rd_pend_q <= 1'b1;
				end else if (out_free) begin
					logic [63:0] nacc;
					logic [3:0] nn;
					logic fin;
					nacc = acc_q | (64'(cbyte) << {n_q[2:0], 3'b000});
					nn = n_q + 4'd1;
					fin = (left_q == 9'd0);
					prod_q <= prod_q + 1'b1;
					fwd_q <= cbyte;
					// next read hits the entry just written when distance is one
					fwd_use_q <= (rptr_q + 1'b1) == prod_q[Aw-1:0];
					rptr_q <= rptr_q + 1'b1;
					if (!fin) begin
						left_q <= left_q - 1'b1;
					end
					if (nn == 4'd8 || fin) begin
						ov_q <= 1'b1;
						od_q <= nacc;
						oc_q <= nn;
						ore_q <= fin;
						obd_q <= fin && last_q;
						ost_q <= lzfd_pkg::ST_OK;
						acc_q <= '0;
						n_q <= '0;
					end else begin
						acc_q <= nacc;
						n_q <= nn;
					end
					if (fin) begin
						copy_q <= 1'b0;
						rd_pend_q <= 1'b0;
						if (last_q) begin
							prod_q <= '0;
						end
					end
				end
			end else if (acc_in) begin
				logic emit;
				logic go;
				logic [3:0] cnt;
				lzfd_pkg::status_t st;
				lzfd_pkg::phase_t nph;
				emit = 1'b0;
				go = 1'b0;
				cnt = '0;
				st = lzfd_pkg::ST_OK;
				nph = phase_q;
				od_q <= '0;
				if (err_q) begin
					emit = s_axis_tlast;
				end else begin
					unique case (phase_q)
						lzfd_pkg::PH_CTRL: begin
							if (s_axis_tdata < 8'd32) begin
								if (need > {1'b0, limit_q}) begin
									st = lzfd_pkg::ST_LIMIT;
								end else begin
									lit_q <= 6'({1'b0, s_axis_tdata[4:0]} + 6'd1);
									nph = lzfd_pkg::PH_LIT;
								end
							end else begin
								clen_q <= {6'd0, s_axis_tdata[7:5]};
								offh_q <= s_axis_tdata[4:0];
								nph = (s_axis_tdata[7:5] == 3'd7) ?
									lzfd_pkg::PH_EXT : lzfd_pkg::PH_OFF;
							end
						end
						lzfd_pkg::PH_LIT: begin
							prod_q <= prod_q + 1'b1;
							emit = 1'b1;
							cnt = 4'd1;
							od_q <= {56'd0, s_axis_tdata};
							lit_q <= lit_q - 1'b1;
							if (lit_q == 6'd1) begin
								nph = lzfd_pkg::PH_CTRL;
							end
						end
						lzfd_pkg::PH_EXT: begin
							clen_q <= clen_q + {1'b0, s_axis_tdata};
							nph = lzfd_pkg::PH_OFF;
						end
						lzfd_pkg::PH_OFF: begin
							nph = lzfd_pkg::PH_CTRL;
							if (need > {1'b0, limit_q}) begin
								st = lzfd_pkg::ST_LIMIT;
							end else if ({{(Cw-14){1'b0}}, back_dist} > prod_q) begin
								st = lzfd_pkg::ST_BEFORE;
							end else begin
								go = 1'b1;
								copy_q <= 1'b1;
								rd_pend_q <= 1'b0;
								last_q <= s_axis_tlast;
								left_q <= 9'(clen_q + 9'd1);
								rptr_q <= Aw'(prod_q[Aw-1:0] - back_dist[Aw-1:0]);
								fwd_use_q <= 1'b0;
								acc_q <= '0;
								n_q <= '0;
							end
						end
						default: ;
					endcase
					if (st != lzfd_pkg::ST_OK) begin
						err_q <= 1'b1;
						emit = 1'b1;
					end else if (s_axis_tlast && nph != lzfd_pkg::PH_CTRL) begin
						st = lzfd_pkg::ST_TRUNC;
					end
					// A copy carries the end of the block on its own last word.
					if (s_axis_tlast && !go) begin
						emit = 1'b1;
					end
				end
				phase_q <= nph;
				if (emit) begin
					ov_q <= 1'b1;
					oc_q <= cnt;
					ore_q <= 1'b1;
					obd_q <= s_axis_tlast;
					ost_q <= st;
				end
				if (s_axis_tlast) begin
					// a copy that was just started clears the block at its end
					phase_q <= lzfd_pkg::PH_CTRL;
					lit_q <= '0;
					clen_q <= '0;
					offh_q <= '0;
					err_q <= 1'b0;
					if (!go) begin
						prod_q <= '0;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/lzfd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LZF decompressor checker
// Port-level assertions on the decompressor's streams.
// ----------------------------------------------------------------------------
module lzfd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [7:0] m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[3:0] <= 4'd8)
		else $error("byte count above eight");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[5] |-> m_axis_tuser[4])
		else $error("block done without end of byte");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[7:6] != 2'd0 |-> m_axis_tuser[4])
		else $error("status on a word that does not end its byte");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output blocked");
endmodule

bind lzf_stream_decompressor_unit lzfd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
